// ===== hw/rtl/dadw_pkg.sv =====
`timescale 1ns / 1ps

package dadw_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WDAY_W  = 3;
    localparam int DAYS_W  = 10;
    localparam int CENT_W  = 7;   // year / 100 and year % 100 both stay below 128
    localparam int WQ_W    = 11;  // weekday sum / 7 stays below 2048

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [DAYS_W-1:0]  DAYS_RESET = 10'd60;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    // floor(y / 100) = (y * 5243) >> 19 holds for every 14-bit year below 43699.
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // floor(x / 7) is at most one low with (x * 9362) >> 16 for 14-bit x.
    localparam logic [13:0] DIV7_MUL     = 14'd9362;
    localparam int          DIV7_SHIFT   = 16;

    typedef struct packed {
        logic load;
        logic div;
        logic split;
        logic clamp;
        logic step;
        logic wdiv;
        logic wsum;
        logic wmul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic step_done;
        logic out_blocked;
    } t_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Sakamoto month offsets, indexed by month 1..12.
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] off;
        unique case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            default: off = 3'd4;
        endcase
        return off;
    endfunction

endpackage

// ===== hw/rtl/dadw_ctrl.sv =====
`timescale 1ns / 1ps

module dadw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dadw_pkg::t_status i_status,
    output logic             o_idle,
    output dadw_pkg::t_cmd   o_cmd
);
    import dadw_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV   = 9'b000000010,
        ST_SPLIT = 9'b000000100,
        ST_CLAMP = 9'b000001000,
        ST_STEP  = 9'b000010000,
        ST_WDIV  = 9'b000100000,
        ST_WSUM  = 9'b001000000,
        ST_WMUL  = 9'b010000000,
        ST_WMOD  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_SPLIT;
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = ST_STEP;
            end
            ST_STEP: begin
                if (i_status.step_done) begin
                    n_state = ST_WDIV;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_WDIV: begin
                o_cmd.wdiv = 1'b1;
                n_state    = ST_WSUM;
            end
            ST_WSUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = ST_WMUL;
            end
            ST_WMUL: begin
                o_cmd.wmul = 1'b1;
                n_state    = ST_WMOD;
            end
            ST_WMOD: begin
                // Hold here until the previous result has left the output register.
                if (!i_status.out_blocked) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

// ===== hw/rtl/dadw_dp.sv =====
`timescale 1ns / 1ps

module dadw_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dadw_pkg::t_cmd                     i_cmd,
    output dadw_pkg::t_status                  o_status,
    input  logic                               i_cfg_we,
    input  logic [dadw_pkg::DAYS_W-1:0]        i_cfg_days,
    input  logic [dadw_pkg::DAY_W-1:0]         i_day,
    input  logic [dadw_pkg::MONTH_W-1:0]       i_month,
    input  logic [dadw_pkg::YEAR_W-1:0]        i_year,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [dadw_pkg::DAY_W-1:0]         o_day,
    output logic [dadw_pkg::MONTH_W-1:0]       o_month,
    output logic [dadw_pkg::YEAR_W-1:0]        o_year,
    output logic [dadw_pkg::WDAY_W-1:0]        o_wday,
    output logic                               o_ovf
);
    import dadw_pkg::*;

    localparam int PROD_W  = YEAR_W + 13;
    localparam int PROD7_W = 2 * YEAR_W;

    logic [DAYS_W-1:0]  r_days, n_days;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [CENT_W-1:0]  r_cent, n_cent;   // year / 100
    logic [CENT_W-1:0]  r_r100, n_r100;   // year % 100
    logic [DAYS_W-1:0]  r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [YEAR_W-1:0]  r_yy, n_yy;
    logic [YEAR_W-1:0]  r_x, n_x;
    logic [WQ_W-1:0]    r_wq, n_wq;
    logic               r_out_valid, n_out_valid;
    logic [DAY_W-1:0]   r_o_day, n_o_day;
    logic [MONTH_W-1:0] r_o_month, n_o_month;
    logic [YEAR_W-1:0]  r_o_year, n_o_year;
    logic [WDAY_W-1:0]  r_o_wday, n_o_wday;
    logic               r_o_ovf, n_o_ovf;

    logic               w_leap;
    logic [DAY_W-1:0]   w_mlen;
    logic [YEAR_W-1:0]  w_yy;
    logic [YEAR_W-1:0]  w_div_in;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD7_W-1:0] w_prod7;
    logic [YEAR_W:0]    w_sum;
    logic [3:0]         w_rem;

    // Leap test from the tracked quotient and remainder by 100.
    assign w_leap = ((r_year[1:0] == 2'd0) && (r_r100 != '0)) ||
                    ((r_r100 == '0) && (r_cent[1:0] == 2'd0));
    assign w_mlen = month_len(r_month, w_leap);

    assign w_yy     = (r_month < MONTH_MAR) ? r_year - YEAR_W'(1) : r_year;
    // One reciprocal multiplier serves both divisions by 100.
    assign w_div_in = i_cmd.wdiv ? w_yy : r_year;
    assign w_prod   = PROD_W'(w_div_in) * PROD_W'(DIV100_MUL);
    assign w_prod7  = PROD7_W'(r_x) * PROD7_W'(DIV7_MUL);

    assign w_sum = (YEAR_W+1)'(r_yy) + (YEAR_W+1)'(r_yy[YEAR_W-1:2])
                 - (YEAR_W+1)'(r_cent) + (YEAR_W+1)'(r_cent[CENT_W-1:2])
                 + (YEAR_W+1)'(month_offset(r_month)) + (YEAR_W+1)'(r_day);

    assign w_rem = 4'(r_x - YEAR_W'(r_wq) * YEAR_W'(7));

    always_comb begin
        n_days      = r_days;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_cent      = r_cent;
        n_r100      = r_r100;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_yy        = r_yy;
        n_x         = r_x;
        n_wq        = r_wq;
        n_out_valid = r_out_valid;
        n_o_day     = r_o_day;
        n_o_month   = r_o_month;
        n_o_year    = r_o_year;
        n_o_wday    = r_o_wday;
        n_o_ovf     = r_o_ovf;

        if (i_cfg_we) begin
            n_days = i_cfg_days;
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_day   = (i_day == '0) ? DAY_W'(1) : i_day;
            n_month = (i_month == '0) ? MONTH_JAN :
                      (i_month > MONTH_DEC) ? MONTH_DEC : i_month;
            n_year  = (i_year == '0) ? YEAR_W'(1) :
                      (i_year > YEAR_MAX) ? YEAR_MAX : i_year;
            n_cnt   = '0;
            n_ovf   = 1'b0;
        end

        if (i_cmd.div || i_cmd.wdiv) begin
            n_cent = w_prod[DIV100_SHIFT +: CENT_W];
        end

        if (i_cmd.wdiv) begin
            n_yy = w_yy;
        end

        if (i_cmd.split) begin
            n_r100 = CENT_W'(r_year - YEAR_W'(r_cent) * YEAR_W'(100));
        end

        if (i_cmd.clamp && (r_day > w_mlen)) begin
            n_day = w_mlen;
        end

        if (i_cmd.step) begin
            n_cnt = r_cnt + DAYS_W'(1);
            if (r_day < w_mlen) begin
                n_day = r_day + DAY_W'(1);
            end else if (r_month < MONTH_DEC) begin
                n_day   = DAY_W'(1);
                n_month = r_month + MONTH_W'(1);
            end else if (r_year < YEAR_MAX) begin
                n_day   = DAY_W'(1);
                n_month = MONTH_JAN;
                n_year  = r_year + YEAR_W'(1);
                if (r_r100 == CENT_W'(99)) begin
                    n_r100 = '0;
                    n_cent = r_cent + CENT_W'(1);
                end else begin
                    n_r100 = r_r100 + CENT_W'(1);
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_cmd.wsum) begin
            n_x = w_sum[YEAR_W-1:0];
        end

        if (i_cmd.wmul) begin
            n_wq = w_prod7[DIV7_SHIFT +: WQ_W];
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_o_day     = r_day;
            n_o_month   = r_month;
            n_o_year    = r_year;
            n_o_wday    = (w_rem >= 4'd7) ? WDAY_W'(w_rem - 4'd7) : WDAY_W'(w_rem);
            n_o_ovf     = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_days      <= DAYS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_days      <= n_days;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day     <= n_day;
        r_month   <= n_month;
        r_year    <= n_year;
        r_cent    <= n_cent;
        r_r100    <= n_r100;
        r_cnt     <= n_cnt;
        r_ovf     <= n_ovf;
        r_yy      <= n_yy;
        r_x       <= n_x;
        r_wq      <= n_wq;
        r_o_day   <= n_o_day;
        r_o_month <= n_o_month;
        r_o_year  <= n_o_year;
        r_o_wday  <= n_o_wday;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_status.step_done   = (r_cnt == r_days) || r_ovf;
    assign o_status.out_blocked = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_day       = r_o_day;
    assign o_month     = r_o_month;
    assign o_year      = r_o_year;
    assign o_wday      = r_o_wday;
    assign o_ovf       = r_o_ovf;

endmodule

// ===== hw/rtl/date_add_days_weekday_core.sv =====
`timescale 1ns / 1ps
// Time from request accept to result valid grows with days_to_add and is shorter when the
// date saturates at 31-12-9999; the day-by-day stepping loop sets it.
// One request at a time: a new request is taken once the
// previous one has reached the output register.
// Reset (synchronous, active low): controller idle, output empty, days_to_add = 60.
module date_add_days_weekday_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: days_to_add
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dadw_pkg::DAYS_W-1:0] i_cfg_data,
    // Input request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [dadw_pkg::S_DATA_W-1:0] s_axis_tdata, // start_day, start_month, start_year
    // Result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [dadw_pkg::M_DATA_W-1:0] m_axis_tdata, // end_day, end_month, end_year, weekday
    output logic        m_axis_tuser  // year_overflow
);
    import dadw_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic              w_idle;
    logic [DAY_W-1:0]   w_day;
    logic [MONTH_W-1:0] w_month;
    logic [YEAR_W-1:0]  w_year;
    logic [WDAY_W-1:0]  w_wday;

    assign s_axis_tready = w_idle;
    assign o_cfg_ready   = 1'b1;

    dadw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_axis_tvalid),
        .i_status (w_status),
        .o_idle   (w_idle),
        .o_cmd    (w_cmd)
    );

    dadw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_days  (i_cfg_data),
        .i_day       (s_axis_tdata[4:0]),
        .i_month     (s_axis_tdata[8:5]),
        .i_year      (s_axis_tdata[22:9]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_day       (w_day),
        .o_month     (w_month),
        .o_year      (w_year),
        .o_wday      (w_wday),
        .o_ovf       (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, w_wday, w_year, w_month, w_day};

endmodule
